### hw/rtl/ipd_dac_pkg.sv
// constants, widths and register indexes for the incremental pd dac controller
// no dependencies; used by incremental_pd_dac_controller_core
`default_nettype none

package ipd_dac_pkg;

   localparam int MEAS_W   = 32;
   localparam int GAIN_W   = 24;
   localparam int CODE_W   = 16;
   localparam int FRAC_W   = 16;
   localparam int ACC_W    = CODE_W + FRAC_W;
   localparam int ERR_W    = MEAS_W + 1;
   localparam int SPD_W    = ERR_W + 1;
   localparam int PRODP_W  = GAIN_W + 1 + ERR_W;
   localparam int PRODD_W  = GAIN_W + 1 + SPD_W;
   localparam int SUM_W    = PRODD_W + 1;
   localparam int SCALE_SH = 8;
   localparam int DELTA_W  = SUM_W - SCALE_SH;
   localparam int EXT_W    = DELTA_W + 2;
   localparam int CSR_AW   = 5;
   localparam int CSR_DW   = 32;

   localparam logic [MEAS_W-1:0] TARGET_RST    = '0;
   localparam logic [GAIN_W-1:0] GAIN_PROP_RST = GAIN_W'(1638);
   localparam logic [GAIN_W-1:0] GAIN_DER_RST  = GAIN_W'(393216);
   localparam logic              DIR_RST       = 1'b1;
   localparam logic [CODE_W-1:0] DAC_LOW_RST   = CODE_W'(1);
   localparam logic [CODE_W-1:0] DAC_HIGH_RST  = CODE_W'(65534);

   typedef enum logic [2:0] {
      REG_TARGET     = 3'd0,
      REG_GAIN_PROP  = 3'd1,
      REG_GAIN_DERIV = 3'd2,
      REG_DIRECTION  = 3'd3,
      REG_DAC_LOW    = 3'd4,
      REG_DAC_HIGH   = 3'd5
   } reg_idx_type;

endpackage

`default_nettype wire

### hw/rtl/incremental_pd_dac_controller_core.sv
// velocity-form pd loop driving a dac code from measurement samples
// depends on ipd_dac_pkg
//
// channel   dir  transaction contents
// req_*     in   tdata: measurement[31:0]; tuser: meas_valid[0]
// rsp_*     out  tdata: drive_code[15:0]
// csr_*     in   apb registers target, gain_prop, gain_deriv, direction, dac_low, dac_high
//
// three register stages: input, product sum, accumulator/result
// rsp_tvalid is out_vld_ff, set after the input and product sum registers
// one sample per cycle while not stalled; accumulator add and clamp are combinational
// a sample with meas_valid low is taken but produces no result and changes no loop state
// rsp_tready low stalls only as far back as needed; empty stages keep filling
// synchronous reset clears loop state, pipeline valids and registers to defaults
`default_nettype none

module incremental_pd_dac_controller_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [ipd_dac_pkg::MEAS_W-1:0]       req_tdata,   // measurement[31:0]
   input  wire logic [0:0]                           req_tuser,   // meas_valid[0]
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [ipd_dac_pkg::CODE_W-1:0]            rsp_tdata,   // drive_code[15:0]
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [ipd_dac_pkg::CSR_AW-1:0]       csr_paddr,
   input  wire logic [ipd_dac_pkg::CSR_DW-1:0]       csr_pwdata,
   output logic [ipd_dac_pkg::CSR_DW-1:0]            csr_prdata,
   output logic                                      csr_pready
);

   // configuration registers
   logic [ipd_dac_pkg::MEAS_W-1:0] target_ff;
   logic [ipd_dac_pkg::GAIN_W-1:0] gain_prop_ff;
   logic [ipd_dac_pkg::GAIN_W-1:0] gain_deriv_ff;
   logic                           direction_ff;
   logic [ipd_dac_pkg::CODE_W-1:0] dac_low_ff;
   logic [ipd_dac_pkg::CODE_W-1:0] dac_high_ff;

   logic                           csr_wr;
   logic [2:0]                     csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff     <= ipd_dac_pkg::TARGET_RST;
         gain_prop_ff  <= ipd_dac_pkg::GAIN_PROP_RST;
         gain_deriv_ff <= ipd_dac_pkg::GAIN_DER_RST;
         direction_ff  <= ipd_dac_pkg::DIR_RST;
         dac_low_ff    <= ipd_dac_pkg::DAC_LOW_RST;
         dac_high_ff   <= ipd_dac_pkg::DAC_HIGH_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            ipd_dac_pkg::REG_TARGET:     target_ff     <= csr_pwdata;
            ipd_dac_pkg::REG_GAIN_PROP:  gain_prop_ff  <= csr_pwdata[ipd_dac_pkg::GAIN_W-1:0];
            ipd_dac_pkg::REG_GAIN_DERIV: gain_deriv_ff <= csr_pwdata[ipd_dac_pkg::GAIN_W-1:0];
            ipd_dac_pkg::REG_DIRECTION:  direction_ff  <= csr_pwdata[0];
            ipd_dac_pkg::REG_DAC_LOW:    dac_low_ff    <= csr_pwdata[ipd_dac_pkg::CODE_W-1:0];
            ipd_dac_pkg::REG_DAC_HIGH:   dac_high_ff   <= csr_pwdata[ipd_dac_pkg::CODE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         ipd_dac_pkg::REG_TARGET:     csr_prdata = target_ff;
         ipd_dac_pkg::REG_GAIN_PROP:  csr_prdata = {8'd0, gain_prop_ff};
         ipd_dac_pkg::REG_GAIN_DERIV: csr_prdata = {8'd0, gain_deriv_ff};
         ipd_dac_pkg::REG_DIRECTION:  csr_prdata = {31'd0, direction_ff};
         ipd_dac_pkg::REG_DAC_LOW:    csr_prdata = {16'd0, dac_low_ff};
         ipd_dac_pkg::REG_DAC_HIGH:   csr_prdata = {16'd0, dac_high_ff};
         default:                     csr_prdata = '0;
      endcase
   end

   // pipeline flow control
   logic in_vld_ff,  in_vld_in;
   logic mid_vld_ff, mid_vld_in;
   logic out_vld_ff, out_vld_in;
   logic in_rdy, mid_rdy, out_rdy;

   assign out_rdy    = ~out_vld_ff | rsp_tready;
   assign mid_rdy    = ~mid_vld_ff | out_rdy;
   assign in_rdy     = ~in_vld_ff  | mid_rdy;
   assign req_tready = in_rdy;
   assign rsp_tvalid = out_vld_ff;

   assign in_vld_in  = in_rdy  ? (req_tvalid & req_tuser[0]) : in_vld_ff;
   assign mid_vld_in = mid_rdy ? in_vld_ff  : mid_vld_ff;
   assign out_vld_in = out_rdy ? mid_vld_ff : out_vld_ff;

   // stage 1: sample register, error, speed, products
   logic        [ipd_dac_pkg::MEAS_W-1:0]  meas_ff;
   logic signed [ipd_dac_pkg::ERR_W-1:0]   last_err_ff;
   logic signed [ipd_dac_pkg::ERR_W-1:0]   err_in;
   logic signed [ipd_dac_pkg::SPD_W-1:0]   speed;
   logic signed [ipd_dac_pkg::PRODP_W-1:0] prod_p;
   logic signed [ipd_dac_pkg::PRODD_W-1:0] prod_d;
   logic signed [ipd_dac_pkg::SUM_W-1:0]   sum_ff, sum_in;

   always_comb begin
      err_in = $signed({meas_ff[ipd_dac_pkg::MEAS_W-1], meas_ff})
             - $signed({target_ff[ipd_dac_pkg::MEAS_W-1], target_ff});
      speed  = $signed({err_in[ipd_dac_pkg::ERR_W-1], err_in})
             - $signed({last_err_ff[ipd_dac_pkg::ERR_W-1], last_err_ff});
      prod_p = $signed({1'b0, gain_prop_ff}) * err_in;
      prod_d = $signed({1'b0, gain_deriv_ff}) * speed;
      sum_in = ipd_dac_pkg::SUM_W'(prod_p) + ipd_dac_pkg::SUM_W'(prod_d);
   end

   // stage 2: accumulator update and clamp
   logic        [ipd_dac_pkg::ACC_W-1:0]   accum_ff, accum_in;
   logic signed [ipd_dac_pkg::DELTA_W-1:0] delta;
   logic signed [ipd_dac_pkg::EXT_W-1:0]   acc_base, acc_sum, acc_lo, acc_hi, acc_clip;
   logic        [ipd_dac_pkg::CODE_W-1:0]  drive_ff;

   always_comb begin
      delta    = sum_ff[ipd_dac_pkg::SUM_W-1:ipd_dac_pkg::SCALE_SH];
      acc_base = $signed({{(ipd_dac_pkg::EXT_W-ipd_dac_pkg::ACC_W){1'b0}}, accum_ff});
      acc_lo   = $signed({{(ipd_dac_pkg::EXT_W-ipd_dac_pkg::ACC_W){1'b0}}, dac_low_ff,
                          {ipd_dac_pkg::FRAC_W{1'b0}}});
      acc_hi   = $signed({{(ipd_dac_pkg::EXT_W-ipd_dac_pkg::ACC_W){1'b0}}, dac_high_ff,
                          {ipd_dac_pkg::FRAC_W{1'b0}}});
      if (direction_ff) begin
         acc_sum = acc_base - ipd_dac_pkg::EXT_W'(delta);
      end else begin
         acc_sum = acc_base + ipd_dac_pkg::EXT_W'(delta);
      end
      acc_clip = acc_sum;
      if (acc_clip < acc_lo) begin
         acc_clip = acc_lo;
      end
      if (acc_clip > acc_hi) begin
         acc_clip = acc_hi;
      end
      accum_in = acc_clip[ipd_dac_pkg::ACC_W-1:0];
   end

   assign rsp_tdata = drive_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         mid_vld_ff  <= 1'b0;
         out_vld_ff  <= 1'b0;
         last_err_ff <= '0;
         accum_ff    <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         mid_vld_ff <= mid_vld_in;
         out_vld_ff <= out_vld_in;
         if (mid_rdy && in_vld_ff) begin
            last_err_ff <= err_in;
         end
         if (out_rdy && mid_vld_ff) begin
            accum_ff <= accum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_rdy && req_tvalid) begin
         meas_ff <= req_tdata;
      end
      if (mid_rdy && in_vld_ff) begin
         sum_ff <= sum_in;
      end
      if (out_rdy && mid_vld_ff) begin
         drive_ff <= accum_in[ipd_dac_pkg::ACC_W-1:ipd_dac_pkg::FRAC_W];
      end
   end

   // checks
   a_code_in_range: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && (dac_low_ff <= dac_high_ff)) |->
         ((rsp_tdata >= dac_low_ff) && (rsp_tdata <= dac_high_ff)))
      else $error("drive code outside dac limits");

   a_code_inverted_limits: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && (dac_low_ff > dac_high_ff)) |-> (rsp_tdata == dac_high_ff))
      else $error("drive code not at high limit with inverted limits");

   a_err_hold: assert property (@(posedge clock) disable iff (reset)
      !in_vld_ff |=> $stable(last_err_ff))
      else $error("last error changed without a valid sample");

   a_accum_hold: assert property (@(posedge clock) disable iff (reset)
      !(out_rdy && mid_vld_ff) |=> $stable(accum_ff))
      else $error("accumulator changed without an update");

   a_code_matches_accum: assert property (@(posedge clock) disable iff (reset)
      $past(out_rdy && mid_vld_ff) |->
         (drive_ff == accum_ff[ipd_dac_pkg::ACC_W-1:ipd_dac_pkg::FRAC_W]))
      else $error("result code differs from accumulator");

endmodule

`default_nettype wire

### tb/sv/tb_incremental_pd_dac_controller_core.sv
// self-checking testbench for incremental_pd_dac_controller_core: random stream traffic,
// apb register phases and a transaction-level drive loop predictor checked on every result
// depends on ipd_dac_pkg and incremental_pd_dac_controller_core
module tb_incremental_pd_dac_controller_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MEAS_W   = ipd_dac_pkg::MEAS_W;
   localparam int GAIN_W   = ipd_dac_pkg::GAIN_W;
   localparam int CODE_W   = ipd_dac_pkg::CODE_W;
   localparam int FRAC_W   = ipd_dac_pkg::FRAC_W;
   localparam int ACC_W    = ipd_dac_pkg::ACC_W;
   localparam int ERR_W    = ipd_dac_pkg::ERR_W;
   localparam int SCALE_SH = ipd_dac_pkg::SCALE_SH;
   localparam int CSR_AW   = ipd_dac_pkg::CSR_AW;
   localparam int CSR_DW   = ipd_dac_pkg::CSR_DW;

   localparam int NUM_REGS      = 6;
   localparam int STALL_LIMIT   = 4000;
   localparam int DRAIN_CYCLES  = 8;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_SAMPLES = 120;
   localparam int HOLD_CYCLES   = 64;

   typedef struct {
      logic signed [MEAS_W-1:0] target;
      logic [GAIN_W-1:0]        gain_prop;
      logic [GAIN_W-1:0]        gain_deriv;
      logic                     direction;
      logic [CODE_W-1:0]        dac_low;
      logic [CODE_W-1:0]        dac_high;
   } loop_settings_type;

   logic                clock;
   logic                reset       = 1'b1;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [MEAS_W-1:0]   req_tdata   = '0;  // measurement[31:0]
   logic [0:0]          req_tuser   = '0;  // meas_valid[0]
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic [CODE_W-1:0]   rsp_tdata;         // drive_code[15:0]
   logic                csr_psel    = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr   = '0;
   logic [CSR_DW-1:0]   csr_pwdata  = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   loop_settings_type   settings = '{ipd_dac_pkg::TARGET_RST, ipd_dac_pkg::GAIN_PROP_RST,
                                     ipd_dac_pkg::GAIN_DER_RST, ipd_dac_pkg::DIR_RST,
                                     ipd_dac_pkg::DAC_LOW_RST, ipd_dac_pkg::DAC_HIGH_RST};
   logic signed [ERR_W-1:0] prev_error  = '0;
   logic [ACC_W-1:0]    drive_accum = '0;
   logic [CODE_W-1:0]   codes_due[$];
   logic [CODE_W-1:0]   code_expected;
   int                  mismatch_count  = 0;
   int                  quiet_cycles    = 0;
   int                  rsp_hold_cycles = 0;
   bit                  req_idle_on = 1'b1;
   bit                  rsp_idle_on = 1'b1;

   incremental_pd_dac_controller_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [CODE_W-1:0] step_drive_loop(logic [MEAS_W-1:0] meas);
      longint err, speed, sum, delta, acc, lo, hi;
      err   = longint'($signed(meas)) - longint'(settings.target);
      speed = err - longint'(prev_error);
      prev_error = ERR_W'(err);
      sum   = longint'({1'b0, settings.gain_prop}) * err
            + longint'({1'b0, settings.gain_deriv}) * speed;
      delta = sum >>> SCALE_SH;
      acc   = longint'({1'b0, drive_accum});
      if (settings.direction) acc = acc - delta;
      else acc = acc + delta;
      lo = longint'({1'b0, settings.dac_low}) <<< FRAC_W;
      hi = longint'({1'b0, settings.dac_high}) <<< FRAC_W;
      if (acc < lo) acc = lo;
      if (acc > hi) acc = hi;
      drive_accum = acc[ACC_W-1:0];
      return drive_accum[ACC_W-1:FRAC_W];
   endfunction

   function automatic void apply_setting(int idx, logic [CSR_DW-1:0] value);
      case (idx)
         ipd_dac_pkg::REG_TARGET:     settings.target     = value;
         ipd_dac_pkg::REG_GAIN_PROP:  settings.gain_prop  = value[GAIN_W-1:0];
         ipd_dac_pkg::REG_GAIN_DERIV: settings.gain_deriv = value[GAIN_W-1:0];
         ipd_dac_pkg::REG_DIRECTION:  settings.direction  = value[0];
         ipd_dac_pkg::REG_DAC_LOW:    settings.dac_low    = value[CODE_W-1:0];
         ipd_dac_pkg::REG_DAC_HIGH:   settings.dac_high   = value[CODE_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic logic [CSR_DW-1:0] settings_word(int idx);
      case (idx)
         ipd_dac_pkg::REG_TARGET:     return settings.target;
         ipd_dac_pkg::REG_GAIN_PROP:  return CSR_DW'(settings.gain_prop);
         ipd_dac_pkg::REG_GAIN_DERIV: return CSR_DW'(settings.gain_deriv);
         ipd_dac_pkg::REG_DIRECTION:  return CSR_DW'(settings.direction);
         ipd_dac_pkg::REG_DAC_LOW:    return CSR_DW'(settings.dac_low);
         ipd_dac_pkg::REG_DAC_HIGH:   return CSR_DW'(settings.dac_high);
         default:                     return '0;
      endcase
   endfunction

   function automatic logic [GAIN_W-1:0] draw_gain();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2, 3:    return GAIN_W'($urandom_range(0, 4096));
         4, 5:    return GAIN_W'($urandom_range(0, 262143));
         default: return GAIN_W'($urandom);
      endcase
   endfunction

   function automatic logic [MEAS_W-1:0] draw_measurement();
      int pick, offset;
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
         offset = int'($urandom_range(0, 32'd1 << $urandom_range(0, 20)));
         if ($urandom_range(0, 1) == 1) offset = -offset;
         return settings.target + offset;
      end else if (pick < 18) begin
         return $urandom;
      end else if (pick == 18) begin
         return 32'h7FFF_FFFF;
      end
      return 32'h8000_0000;
   endfunction

   function automatic logic draw_valid();
      return $urandom_range(0, 9) != 0;
   endfunction

   task automatic report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic csr_access(input bit is_write, input int idx, input logic [CSR_DW-1:0] wdata,
                             output logic [CSR_DW-1:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= CSR_AW'(idx * 4);
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic write_setting(int idx, logic [CSR_DW-1:0] value);
      logic [CSR_DW-1:0] unused;
      csr_access(1'b1, idx, value, unused);
      apply_setting(idx, value);
   endtask

   task automatic verify_settings();
      logic [CSR_DW-1:0] word;
      for (int idx = 0; idx < NUM_REGS; idx++) begin
         csr_access(1'b0, idx, '0, word);
         if (word !== settings_word(idx))
            report_mismatch($sformatf("register %0d reads 0x%08h, expected 0x%08h",
                                      idx, word, settings_word(idx)));
      end
   endtask

   task automatic offer_sample(logic [MEAS_W-1:0] meas, logic valid);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= meas;
      req_tuser  <= valid;
      do @(posedge clock); while (!req_tready);
      if (valid) codes_due.push_back(step_drive_loop(meas));
      @(negedge clock);
   endtask

   task automatic settle_loop();
      req_tvalid <= 1'b0;
      while (codes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic randomize_settings();
      logic [CODE_W-1:0] a, b;
      case ($urandom_range(0, 5))
         0:       write_setting(ipd_dac_pkg::REG_TARGET, 32'h8000_0000);
         1:       write_setting(ipd_dac_pkg::REG_TARGET, 32'h7FFF_FFFF);
         2:       write_setting(ipd_dac_pkg::REG_TARGET, $urandom);
         default: write_setting(ipd_dac_pkg::REG_TARGET,
                                $urandom_range(0, 32'h0100_0000) - 32'h0080_0000);
      endcase
      write_setting(ipd_dac_pkg::REG_GAIN_PROP, CSR_DW'(draw_gain()));
      write_setting(ipd_dac_pkg::REG_GAIN_DERIV, CSR_DW'(draw_gain()));
      write_setting(ipd_dac_pkg::REG_DIRECTION, $urandom_range(0, 1));
      a = CODE_W'($urandom);
      b = CODE_W'($urandom);
      case ($urandom_range(0, 7))
         0: begin
            a = '0;
            b = '1;
         end
         1: begin
            a = CODE_W'($urandom_range(32768, 65535));
            b = CODE_W'($urandom_range(0, 32767));
         end
         2: b = a;
         default: if (a > b) {a, b} = {b, a};
      endcase
      write_setting(ipd_dac_pkg::REG_DAC_LOW, CSR_DW'(a));
      write_setting(ipd_dac_pkg::REG_DAC_HIGH, CSR_DW'(b));
   endtask

   task automatic test_reset_state();
      verify_settings();
      write_setting(NUM_REGS, $urandom);
      write_setting(NUM_REGS + 1, $urandom);
      verify_settings();
      // accumulator resets below the low bound
      offer_sample('0, 1'b1);
      offer_sample(32'h7FFF_FFFF, 1'b0);
      offer_sample(32'h0000_0A00, 1'b1);
      offer_sample(32'h8000_0000, 1'b0);
      offer_sample(32'hFFFF_F600, 1'b1);
      settle_loop();
   endtask

   task automatic test_field_extremes();
      write_setting(ipd_dac_pkg::REG_TARGET, 32'h8000_0000);
      write_setting(ipd_dac_pkg::REG_GAIN_PROP, '1);
      write_setting(ipd_dac_pkg::REG_GAIN_DERIV, '1);
      write_setting(ipd_dac_pkg::REG_DIRECTION, 1);
      write_setting(ipd_dac_pkg::REG_DAC_LOW, 0);
      write_setting(ipd_dac_pkg::REG_DAC_HIGH, 32'h0000_FFFF);
      verify_settings();
      offer_sample(32'h7FFF_FFFF, 1'b1);
      offer_sample(32'h8000_0000, 1'b1);
      offer_sample(32'h7FFF_FFFF, 1'b1);
      settle_loop();
      write_setting(ipd_dac_pkg::REG_TARGET, 32'h7FFF_FFFF);
      write_setting(ipd_dac_pkg::REG_DIRECTION, 0);
      offer_sample(32'h8000_0000, 1'b1);
      offer_sample(32'h7FFF_FFFF, 1'b1);
      offer_sample(32'h8000_0000, 1'b1);
      settle_loop();
      write_setting(ipd_dac_pkg::REG_GAIN_PROP, 0);
      write_setting(ipd_dac_pkg::REG_GAIN_DERIV, 0);
      offer_sample(32'hFFFF_FFFF, 1'b1);
      settle_loop();
   endtask

   task automatic test_inverted_bounds();
      // low bound above high bound ends at the high bound
      write_setting(ipd_dac_pkg::REG_TARGET, 0);
      write_setting(ipd_dac_pkg::REG_GAIN_PROP, 32'h0001_0000);
      write_setting(ipd_dac_pkg::REG_GAIN_DERIV, 0);
      write_setting(ipd_dac_pkg::REG_DAC_LOW, 40000);
      write_setting(ipd_dac_pkg::REG_DAC_HIGH, 100);
      offer_sample(32'h0001_0000, 1'b1);
      offer_sample(32'hFFF0_0000, 1'b1);
      settle_loop();
      write_setting(ipd_dac_pkg::REG_DAC_LOW, 1234);
      write_setting(ipd_dac_pkg::REG_DAC_HIGH, 1234);
      offer_sample(32'h0000_5000, 1'b1);
      settle_loop();
   endtask

   task automatic test_direction();
      write_setting(ipd_dac_pkg::REG_DAC_LOW, 0);
      write_setting(ipd_dac_pkg::REG_DAC_HIGH, 32'h0000_FFFF);
      write_setting(ipd_dac_pkg::REG_GAIN_PROP, 32'h0001_0000);
      write_setting(ipd_dac_pkg::REG_GAIN_DERIV, 32'h0000_8000);
      write_setting(ipd_dac_pkg::REG_DIRECTION, 1);
      offer_sample(32'h0000_6400, 1'b1);
      offer_sample(32'hFFFF_CE00, 1'b1);
      settle_loop();
      write_setting(ipd_dac_pkg::REG_DIRECTION, 0);
      offer_sample(32'h0000_6400, 1'b1);
      offer_sample(32'hFFFF_CE00, 1'b1);
      settle_loop();
   endtask

   task automatic test_backpressure();
      req_idle_on = 1'b0;
      rsp_hold_cycles = HOLD_CYCLES;
      repeat (24) offer_sample(draw_measurement(), draw_valid());
      settle_loop();
      req_idle_on = 1'b1;
   endtask

   task automatic test_pause_for_results();
      repeat (3) begin
         repeat (6) offer_sample(draw_measurement(), draw_valid());
         settle_loop();
      end
   endtask

   task automatic test_random_phases();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         randomize_settings();
         verify_settings();
         req_idle_on = (phase != 0) && ($urandom_range(0, 3) != 0);
         rsp_idle_on = (phase != 0) && ($urandom_range(0, 3) != 0);
         repeat (PHASE_SAMPLES) offer_sample(draw_measurement(), draw_valid());
         settle_loop();
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   initial begin : result_sink
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = rsp_idle_on ? $urandom_range(0, 7) : 0;
         if (rsp_hold_cycles != 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (codes_due.size() == 0) begin
            report_mismatch($sformatf("drive_code %0d with no sample pending", rsp_tdata));
         end else begin
            code_expected = codes_due.pop_front();
            if (rsp_tdata !== code_expected)
               report_mismatch($sformatf("drive_code %0d, expected %0d",
                                         rsp_tdata, code_expected));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_psel && csr_penable)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_field_extremes();
      test_inverted_bounds();
      test_direction();
      test_backpressure();
      test_pause_for_results();
      test_random_phases();
      settle_loop();
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
